[hw/rtl/isochronic_tone_mixer_assert.svh]
// Assertion macros shared by the isochronic tone mixer RTL.
// Each macro expects clk and rst_n to be visible in the including scope.
`ifndef ISOCHRONIC_TONE_MIXER_ASSERT_SVH
`define ISOCHRONIC_TONE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/itm_pkg.sv]
// Shared types and constants of the isochronic tone mixer.
// Used by itm_ctrl, itm_dpath and isochronic_tone_mixer; depends on nothing.
package itm_pkg;

  // Default parameter values.
  localparam int unsigned PHASE_BITS_DEF  = 32;
  localparam int unsigned SINE_DEPTH_DEF  = 1024;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned INC_W      = 31;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned MIX_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Shared multiplier: signed 18 x 33 with a 51-bit product.
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Register reset values and mix limit.
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;
  localparam logic [MIX_W-1:0] MIX_ONE   = 17'd65536;

  // Quarter-wave polynomial coefficients.
  localparam logic [16:0] SINE_C1   = 17'd2320;
  localparam logic [16:0] SINE_C2   = 17'd21024;
  localparam logic [16:0] SINE_C3   = 17'd51472;
  localparam logic [16:0] Q15_LIMIT = 17'd32767;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_INC = 3'd0,
    REG_PULSE_INC   = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_MASKING_MIX = 3'd3,
    REG_MUSIC_EN    = 3'd4
  } cfg_reg_t;

  // Datapath step codes, one per use of the shared multiplier.
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_IDX  = 4'd1,
    OP_ANG  = 4'd2,
    OP_T2   = 4'd3,
    OP_Y1   = 4'd4,
    OP_Y2   = 4'd5,
    OP_Y3   = 4'd6,
    OP_AMP  = 4'd7,
    OP_TONE = 4'd8,
    OP_MIX  = 4'd9
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t  op;
    logic take;
    logic stop;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic gate_open;
  } sts_t;

endpackage

[hw/rtl/isochronic_tone_mixer.sv]
// Top level of the isochronic tone mixer: configuration registers and the
// controller and datapath instances. Depends on itm_pkg, itm_ctrl and itm_dpath.
//
//   Channel  Direction  Handshake               Beat payload
//   in_      input      in_valid / in_ready     kind, music sample and flag, noise sample
//   out_     output     out_valid / out_ready   left and right samples (equal)
//   cfg_     input      cfg_valid / cfg_ready   register index and write data
//
// A produce beat with the pulse gate open runs every sine, amplitude and mix step before
// out_valid rises; with the gate closed it runs the mix steps alone. The next input beat
// can follow as soon as the result is loaded. The order of steps is set by one 18x33
// multiplier that the nine products of the sine, amplitude and mix steps share in turn;
// a closed gate needs only the two mix products.
// A stop beat clears both phases in its accept cycle and yields nothing.
// Reset is synchronous and active low; it clears the phases and loads register defaults.
// A result held by a stalled out_ready does not block the next input beat; only the
// final load of the rounded sum waits for the output register to empty.

module isochronic_tone_mixer #(
  parameter int unsigned PHASE_BITS       = itm_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = itm_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic signed [itm_pkg::SAMPLE_W-1:0]   in_music_sample,
  input  logic                                  in_music_valid,
  input  logic signed [itm_pkg::SAMPLE_W-1:0]   in_noise_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [itm_pkg::SAMPLE_W-1:0]   out_left_sample,
  output logic signed [itm_pkg::SAMPLE_W-1:0]   out_right_sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [itm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [itm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [itm_pkg::INC_W-1:0] carrier_inc_r, pulse_inc_r;
  logic [itm_pkg::AMP_W-1:0] amplitude_r;
  logic [itm_pkg::MIX_W-1:0] mix_r;
  logic                      music_en_r;
  logic signed [itm_pkg::SAMPLE_W-1:0] sample;
  itm_pkg::cmd_t             cmd;
  itm_pkg::sts_t             sts;

  // Registers are always writable; the user writes them only while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_inc_r <= '0;
      pulse_inc_r   <= '0;
      amplitude_r   <= itm_pkg::AMP_RESET;
      mix_r         <= '0;
      music_en_r    <= 1'b0;
    end else if (cfg_valid) begin
      // Indexes past the last register are dropped.
      unique case (cfg_index)
        itm_pkg::REG_CARRIER_INC: carrier_inc_r <= cfg_data[itm_pkg::INC_W-1:0];
        itm_pkg::REG_PULSE_INC:   pulse_inc_r   <= cfg_data[itm_pkg::INC_W-1:0];
        itm_pkg::REG_AMPLITUDE:   amplitude_r   <= cfg_data[itm_pkg::AMP_W-1:0];
        itm_pkg::REG_MASKING_MIX: mix_r         <= cfg_data[itm_pkg::MIX_W-1:0];
        itm_pkg::REG_MUSIC_EN:    music_en_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  itm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itm_dpath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_music_sample   (in_music_sample),
    .in_music_valid    (in_music_valid),
    .in_noise_sample   (in_noise_sample),
    .carrier_increment (carrier_inc_r),
    .pulse_increment   (pulse_inc_r),
    .amplitude         (amplitude_r),
    .masking_mix       (mix_r),
    .music_enable      (music_en_r),
    .out_sample        (sample)
  );

  // Both stereo channels carry the same mixed sample.
  assign out_left_sample  = sample;
  assign out_right_sample = sample;

endmodule

[hw/rtl/itm_ctrl.sv]
// Sequencer of the isochronic tone mixer: handshakes and step commands.
// Depends on itm_pkg and isochronic_tone_mixer_assert.svh.
`include "isochronic_tone_mixer_assert.svh"

module itm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  itm_pkg::sts_t sts,
  output itm_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_IDX  = 11'b00000000010,
    ST_ANG  = 11'b00000000100,
    ST_T2   = 11'b00000001000,
    ST_Y1   = 11'b00000010000,
    ST_Y2   = 11'b00000100000,
    ST_Y3   = 11'b00001000000,
    ST_AMP  = 11'b00010000000,
    ST_TONE = 11'b00100000000,
    ST_MIX  = 11'b01000000000,
    ST_SUM  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = itm_pkg::OP_NONE;
    cmd.take     = 1'b0;
    cmd.stop     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            cmd.stop = 1'b1;
          end else begin
            cmd.take  = 1'b1;
            // A closed gate needs no sine: go straight to the mix.
            state_nxt = sts.gate_open ? ST_IDX : ST_TONE;
          end
        end
      end
      ST_IDX: begin
        cmd.op    = itm_pkg::OP_IDX;
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        cmd.op    = itm_pkg::OP_ANG;
        state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd.op    = itm_pkg::OP_T2;
        state_nxt = ST_Y1;
      end
      ST_Y1: begin
        cmd.op    = itm_pkg::OP_Y1;
        state_nxt = ST_Y2;
      end
      ST_Y2: begin
        cmd.op    = itm_pkg::OP_Y2;
        state_nxt = ST_Y3;
      end
      ST_Y3: begin
        cmd.op    = itm_pkg::OP_Y3;
        state_nxt = ST_AMP;
      end
      ST_AMP: begin
        cmd.op    = itm_pkg::OP_AMP;
        state_nxt = ST_TONE;
      end
      ST_TONE: begin
        cmd.op    = itm_pkg::OP_TONE;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.op    = itm_pkg::OP_MIX;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // Hold the finished sum until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ITM_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result overwritten before taken")
  `ITM_ASSERT_NXT(a_busy_after_take, cmd.take, !in_ready, "ready while a sample is in work")
  `ITM_ASSERT_NXT(a_closed_short_path, cmd.take && !sts.gate_open, state_r == ST_TONE, "closed gate did not skip the sine")

endmodule

[hw/rtl/itm_dpath.sv]
// Datapath of the isochronic tone mixer: phases, shared multiplier, mix and saturation.
// Depends on itm_pkg and isochronic_tone_mixer_assert.svh.
`include "isochronic_tone_mixer_assert.svh"

module itm_dpath #(
  parameter int unsigned PHASE_BITS       = itm_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = itm_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  itm_pkg::cmd_t                       cmd,
  output itm_pkg::sts_t                       sts,
  input  logic signed [itm_pkg::SAMPLE_W-1:0] in_music_sample,
  input  logic                                in_music_valid,
  input  logic signed [itm_pkg::SAMPLE_W-1:0] in_noise_sample,
  input  logic [itm_pkg::INC_W-1:0]           carrier_increment,
  input  logic [itm_pkg::INC_W-1:0]           pulse_increment,
  input  logic [itm_pkg::AMP_W-1:0]           amplitude,
  input  logic [itm_pkg::MIX_W-1:0]           masking_mix,
  input  logic                                music_enable,
  output logic signed [itm_pkg::SAMPLE_W-1:0] out_sample
);

  localparam int unsigned IDX_W     = $clog2(SINE_TABLE_DEPTH);
  // The table point angle idx * 2^16 / depth is taken as (idx * ANG_RECIP) >> ANG_SHIFT,
  // exact because 2^ANG_SHIFT is at least the square of the depth.
  localparam int unsigned ANG_SHIFT = 2 * IDX_W;
  localparam logic [63:0] ANG_RECIP =
    ((64'd1 << (16 + ANG_SHIFT)) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH);
  localparam int unsigned SUM_W     = 36;
  localparam logic signed [19:0] SAT_MAX = 20'sd32767;
  localparam logic signed [19:0] SAT_MIN = -20'sd32768;

  localparam int unsigned AW = itm_pkg::MUL_A_W;
  localparam int unsigned BW = itm_pkg::MUL_B_W;
  localparam int unsigned PW = itm_pkg::PROD_W;

  logic [PHASE_BITS-1:0]  carrier_r, pulse_r;
  logic [PHASE_BITS+30:0] carrier_sum, pulse_sum;
  logic [PHASE_BITS-1:0]  carrier_base;
  logic [15:0]            p16_r;
  logic                   open_r;
  logic signed [16:0]     mn_r, mn_nxt;
  logic signed [15:0]     music_sel;
  logic signed [PW-1:0]   prod_r, acc_r, product;
  logic [15:0]            t_r;
  logic [16:0]            t2_r;
  logic                   neg_r;
  logic signed [15:0]     out_sample_r;

  logic [IDX_W-1:0]       idx;
  logic [15:0]            a16;
  logic [1:0]             quad;
  logic [15:0]            t_base, t_fold;
  logic [16:0]            prod_q15, y2, y3;
  logic [14:0]            s_mag;
  logic signed [16:0]     tone_mag, tone;
  logic [16:0]            mix_w, mix_inv;
  logic signed [AW-1:0]   a_op;
  logic signed [BW-1:0]   b_op;
  logic signed [SUM_W-1:0] sum, rnd;
  logic signed [19:0]     q;
  logic signed [15:0]     sat;

  // Phase accumulators; a closed gate restarts the carrier from zero.
  assign sts.gate_open = ~pulse_r[PHASE_BITS-1];
  assign carrier_base  = sts.gate_open ? carrier_r : '0;
  assign carrier_sum   = {31'd0, carrier_base} + {{PHASE_BITS{1'b0}}, carrier_increment};
  assign pulse_sum     = {31'd0, pulse_r} + {{PHASE_BITS{1'b0}}, pulse_increment};

  assign music_sel = (in_music_valid && music_enable) ? in_music_sample : '0;
  assign mn_nxt    = {music_sel[15], music_sel} + {in_noise_sample[15], in_noise_sample};

  // Previous product seen in the forms the steps need.
  assign prod_q15 = prod_r[15 +: 17];
  assign idx      = prod_r[16 +: IDX_W];
  assign a16      = prod_r[ANG_SHIFT +: 16];
  assign quad     = a16[15:14];
  assign t_base   = {1'b0, a16[13:0], 1'b0};
  assign t_fold   = quad[0] ? (16'd32768 - t_base) : t_base;
  assign y2       = itm_pkg::SINE_C2 - prod_q15;
  assign y3       = itm_pkg::SINE_C3 - prod_q15;
  assign s_mag    = (prod_q15 > itm_pkg::Q15_LIMIT) ? 15'd32767 : prod_q15[14:0];
  assign tone_mag = {2'b00, prod_q15[14:0]};
  assign tone     = !open_r ? '0 : (neg_r ? -tone_mag : tone_mag);
  assign mix_w    = (masking_mix > itm_pkg::MIX_ONE) ? itm_pkg::MIX_ONE : masking_mix;
  assign mix_inv  = itm_pkg::MIX_ONE - mix_w;

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.op)
      itm_pkg::OP_IDX: begin
        a_op = {2'b00, p16_r};
        b_op = BW'(SINE_TABLE_DEPTH);
      end
      itm_pkg::OP_ANG: begin
        a_op = AW'(idx);
        b_op = BW'(ANG_RECIP);
      end
      itm_pkg::OP_T2: begin
        a_op = {2'b00, t_fold};
        b_op = BW'(t_fold);
      end
      itm_pkg::OP_Y1: begin
        a_op = {1'b0, prod_q15};
        b_op = BW'(itm_pkg::SINE_C1);
      end
      itm_pkg::OP_Y2: begin
        a_op = {1'b0, y2};
        b_op = BW'(t2_r);
      end
      itm_pkg::OP_Y3: begin
        a_op = {1'b0, y3};
        b_op = BW'(t_r);
      end
      itm_pkg::OP_AMP: begin
        a_op = {3'b000, s_mag};
        b_op = BW'(amplitude);
      end
      itm_pkg::OP_TONE: begin
        a_op = {tone[16], tone};
        b_op = BW'(mix_inv);
      end
      itm_pkg::OP_MIX: begin
        a_op = {mn_r[16], mn_r};
        b_op = BW'(mix_w);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign product = a_op * b_op;

  // Round half up, then saturate to the sample range.
  assign sum = acc_r[SUM_W-1:0] + prod_r[SUM_W-1:0];
  assign rnd = sum + 36'sd32768;
  assign q   = rnd[SUM_W-1:16];
  always_comb begin
    if (q > SAT_MAX) begin
      sat = 16'sd32767;
    end else if (q < SAT_MIN) begin
      sat = -16'sd32768;
    end else begin
      sat = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= '0;
      pulse_r   <= '0;
    end else if (cmd.stop) begin
      carrier_r <= '0;
      pulse_r   <= '0;
    end else if (cmd.take) begin
      carrier_r <= carrier_sum[PHASE_BITS-1:0];
      pulse_r   <= pulse_sum[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p16_r  <= carrier_r[PHASE_BITS-1 -: 16];
      open_r <= sts.gate_open;
      mn_r   <= mn_nxt;
    end
    if (cmd.op != itm_pkg::OP_NONE) begin
      prod_r <= product;
    end
    if (cmd.op == itm_pkg::OP_T2) begin
      t_r   <= t_fold;
      neg_r <= quad[1];
    end
    if (cmd.op == itm_pkg::OP_Y1) begin
      t2_r <= prod_q15;
    end
    if (cmd.op == itm_pkg::OP_MIX) begin
      acc_r <= prod_r;
    end
    if (cmd.load_out) begin
      out_sample_r <= sat;
    end
  end

  assign out_sample = out_sample_r;

  `ITM_ASSERT_NXT(a_stop_clears, cmd.stop, (carrier_r == '0) && (pulse_r == '0), "stop left a phase set")
  `ITM_ASSERT_NXT(a_closed_tone_zero, (cmd.op == itm_pkg::OP_TONE) && !open_r, prod_r == '0, "closed gate let tone through")

endmodule

[tb/isochronic_tone_mixer_tb.sv]
// Self-checking testbench for the isochronic tone mixer: directed and random beats
// against a bit-exact predictor of the two oscillators, the gate and the mix.
// Depends on itm_pkg and the isochronic_tone_mixer RTL; needs no other files.

module isochronic_tone_mixer_tb;

  // Beat kinds on the input channel.
  localparam logic KIND_PRODUCE = 1'b0;
  localparam logic KIND_STOP    = 1'b1;

  // Register indexes past the last mapped one. Writes to them must be dropped.
  localparam logic [itm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [itm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int unsigned PHASE_W = itm_pkg::PHASE_BITS_DEF;

  localparam logic signed [itm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [itm_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // These leave room for a beat still in flight, even the slowest one.
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned DRAIN_CYCLES    = 32;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned BEATS_PER_PHASE = 115;

  // Predicts the mixed sample of each produce beat and checks the samples that come out.
  // It keeps its own copy of the register file and of both phase accumulators.
  class tone_scoreboard;
    logic [itm_pkg::INC_W-1:0]           carrier_step;
    logic [itm_pkg::INC_W-1:0]           pulse_step;
    logic [itm_pkg::AMP_W-1:0]           amp_gain;
    logic [itm_pkg::MIX_W-1:0]           mix_weight;
    logic                                music_on;
    logic [PHASE_W-1:0]                  carrier_ph;
    logic [PHASE_W-1:0]                  pulse_ph;
    logic signed [itm_pkg::SAMPLE_W-1:0] expected_samples[$];
    int unsigned                         errors;

    function new();
      carrier_step = '0;
      pulse_step   = '0;
      amp_gain     = itm_pkg::AMP_RESET;
      mix_weight   = '0;
      music_on     = 1'b0;
      carrier_ph   = '0;
      pulse_ph     = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [itm_pkg::CFG_IDX_W-1:0] idx,
                            logic [itm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        itm_pkg::REG_CARRIER_INC: carrier_step = data[itm_pkg::INC_W-1:0];
        itm_pkg::REG_PULSE_INC:   pulse_step = data[itm_pkg::INC_W-1:0];
        itm_pkg::REG_AMPLITUDE:   amp_gain = data[itm_pkg::AMP_W-1:0];
        itm_pkg::REG_MASKING_MIX: mix_weight = data[itm_pkg::MIX_W-1:0];
        itm_pkg::REG_MUSIC_EN:    music_on = data[0];
        default: ;
      endcase
    endfunction

    // Signed Q15 sine of a phase, taken at the nearest lower table point.
    function longint sine_q15(logic [PHASE_W-1:0] ph);
      longint unsigned p16, idx, a16, t, t2, y;
      p16 = ph >> (PHASE_W - 16);
      idx = (p16 * itm_pkg::SINE_DEPTH_DEF) >> 16;
      a16 = ((idx << 16) / itm_pkg::SINE_DEPTH_DEF) & 64'hFFFF;
      t   = (a16 & 64'h3FFF) << 1;
      if (a16[14]) t = 64'd32768 - t;
      t2 = (t * t) >> 15;
      y  = (itm_pkg::SINE_C1 * t2) >> 15;
      y  = itm_pkg::SINE_C2 - y;
      y  = (y * t2) >> 15;
      y  = itm_pkg::SINE_C3 - y;
      y  = (y * t) >> 15;
      if (y > itm_pkg::Q15_LIMIT) y = itm_pkg::Q15_LIMIT;
      return a16[15] ? -longint'(y) : longint'(y);
    endfunction

    function void note_beat(logic kind, logic signed [itm_pkg::SAMPLE_W-1:0] music,
                            logic music_ok, logic signed [itm_pkg::SAMPLE_W-1:0] noise);
      longint sine, tone, weight, sum, mixed;
      if (kind == KIND_STOP) begin
        carrier_ph = '0;
        pulse_ph   = '0;
        return;
      end
      sine = sine_q15(carrier_ph);
      tone = ((sine < 0 ? -sine : sine) * longint'(amp_gain)) >>> 15;
      if (sine < 0) tone = -tone;
      // The second half of the pulse turn mutes the tone and restarts the carrier.
      if (pulse_ph[PHASE_W-1]) begin
        tone       = 0;
        carrier_ph = '0;
      end
      carrier_ph = carrier_ph + carrier_step;
      pulse_ph   = pulse_ph + pulse_step;
      weight = (mix_weight > itm_pkg::MIX_ONE) ? longint'(itm_pkg::MIX_ONE)
                                               : longint'(mix_weight);
      sum = (longint'(itm_pkg::MIX_ONE) - weight) * tone + weight * longint'(noise);
      if (music_ok && music_on) sum += weight * longint'(music);
      mixed = (sum + 32768) >>> 16;
      if (mixed > SAMPLE_MAX) mixed = SAMPLE_MAX;
      if (mixed < SAMPLE_MIN) mixed = SAMPLE_MIN;
      expected_samples.push_back(itm_pkg::SAMPLE_W'(mixed));
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [itm_pkg::SAMPLE_W-1:0] left,
                      logic signed [itm_pkg::SAMPLE_W-1:0] right);
      logic signed [itm_pkg::SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with none outstanding", left));
        return;
      end
      want = expected_samples.pop_front();
      if (left !== want)
        report_mismatch($sformatf("left sample %0d, expected %0d", left, want));
      if (right !== want)
        report_mismatch($sformatf("right sample %0d, expected %0d", right, want));
    endtask

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_kind = KIND_PRODUCE;
  logic signed [itm_pkg::SAMPLE_W-1:0] in_music_sample = '0;
  logic                                in_music_valid = 1'b0;
  logic signed [itm_pkg::SAMPLE_W-1:0] in_noise_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [itm_pkg::SAMPLE_W-1:0] out_left_sample;
  logic signed [itm_pkg::SAMPLE_W-1:0] out_right_sample;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [itm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [itm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  tone_scoreboard sb;

  // Idle odds for each side: one chance in N per beat or cycle, zero for none at all.
  int unsigned gap_odds   = 4;
  int unsigned stall_odds = 4;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  isochronic_tone_mixer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_music_sample  (in_music_sample),
    .in_music_valid   (in_music_valid),
    .in_noise_sample  (in_noise_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side drops ready in random bursts. A burst that is under way
  // runs to its end even after the odds drop to zero.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left <= $urandom_range(1, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result beat is checked against the oldest prediction. Signals are read in the
  // edge's active region, so they hold the values from before this edge's updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_left_sample, out_right_sample);
  end

  // The watchdog ends a hung run. Any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [itm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return itm_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 4;
      default: return 8;
    endcase
  endfunction

  // Presents one input beat, after an optional idle gap, and holds it until it is
  // taken. Valid stays high on return so that back-to-back beats never drop it.
  task automatic send_beat(input logic kind,
                           input logic signed [itm_pkg::SAMPLE_W-1:0] music,
                           input logic music_ok,
                           input logic signed [itm_pkg::SAMPLE_W-1:0] noise);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_music_sample <= music;
    in_music_valid  <= music_ok;
    in_noise_sample <= noise;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(kind, music, music_ok, noise);
  endtask

  task automatic random_beat();
    logic kind;
    kind = ($urandom_range(0, 39) == 0) ? KIND_STOP : KIND_PRODUCE;
    send_beat(kind, pick_sample(), $urandom_range(0, 3) != 0, pick_sample());
  endtask

  task automatic write_reg(input logic [itm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [itm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Registers only change while the block is idle: every predicted sample has come
  // out, and a stop beat that yields nothing has had time to finish as well.
  task automatic configure(input logic [itm_pkg::INC_W-1:0] carrier,
                           input logic [itm_pkg::INC_W-1:0] pulse,
                           input logic [itm_pkg::AMP_W-1:0] amp,
                           input logic [itm_pkg::MIX_W-1:0] mix,
                           input logic music_en, input logic poke_unmapped);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (poke_unmapped)
      write_reg(itm_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                itm_pkg::CFG_DATA_W'($urandom));
    write_reg(itm_pkg::REG_CARRIER_INC, carrier);
    write_reg(itm_pkg::REG_PULSE_INC, pulse);
    write_reg(itm_pkg::REG_AMPLITUDE, itm_pkg::CFG_DATA_W'(amp));
    write_reg(itm_pkg::REG_MASKING_MIX, itm_pkg::CFG_DATA_W'(mix));
    write_reg(itm_pkg::REG_MUSIC_EN, itm_pkg::CFG_DATA_W'(music_en));
    cfg_valid <= 1'b0;
  endtask

  // Random settings lean on the extremes. Pulse steps mostly fall in a band where the
  // gate opens and closes several times per phase between stop beats.
  task automatic random_config();
    logic [itm_pkg::INC_W-1:0] carrier, pulse;
    logic [itm_pkg::AMP_W-1:0] amp;
    logic [itm_pkg::MIX_W-1:0] mix;
    case ($urandom_range(0, 3))
      0: carrier = itm_pkg::INC_W'($urandom_range(0, 1 << 20));
      1: carrier = '1;
      default: carrier = itm_pkg::INC_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: pulse = '0;
      1: pulse = '1;
      default: pulse = itm_pkg::INC_W'($urandom_range(1 << 25, 1 << 29));
    endcase
    case ($urandom_range(0, 3))
      0: amp = '0;
      1: amp = '1;
      default: amp = itm_pkg::AMP_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: mix = '0;
      1: mix = itm_pkg::MIX_ONE;
      2: mix = itm_pkg::MIX_W'($urandom_range(itm_pkg::MIX_ONE + 1,
                                              (1 << itm_pkg::MIX_W) - 1));
      default: mix = itm_pkg::MIX_W'($urandom_range(0, itm_pkg::MIX_ONE));
    endcase
    configure(carrier, pulse, amp, mix, $urandom_range(0, 1) != 0, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero carrier step, so the tone is silent and the mix weight is zero.
    send_beat(KIND_PRODUCE, SAMPLE_MAX, 1'b1, SAMPLE_MIN);
    send_beat(KIND_PRODUCE, SAMPLE_MIN, 1'b1, SAMPLE_MAX);

    // A quarter-turn carrier walks through all four sine quadrants. The pulse step makes
    // the gate open for eight samples and then close, which also restarts the carrier.
    // A stop in the middle clears both phases. An unmapped write goes in first.
    configure(itm_pkg::INC_W'(32'h4000_0000), itm_pkg::INC_W'(32'h1000_0000),
              itm_pkg::AMP_RESET, '0, 1'b1, 1'b1);
    repeat (12) send_beat(KIND_PRODUCE, pick_sample(), 1'b1, pick_sample());
    send_beat(KIND_STOP, pick_sample(), 1'b1, pick_sample());
    send_beat(KIND_PRODUCE, pick_sample(), 1'b1, pick_sample());

    // Full mix with zero amplitude: music plus noise saturates at both ends, and a
    // beat without valid music leaves only the noise.
    configure('1, '0, '0, itm_pkg::MIX_ONE, 1'b1, 1'b0);
    send_beat(KIND_PRODUCE, SAMPLE_MAX, 1'b1, SAMPLE_MAX);
    send_beat(KIND_PRODUCE, SAMPLE_MIN, 1'b1, SAMPLE_MIN);
    send_beat(KIND_PRODUCE, SAMPLE_MAX, 1'b0, SAMPLE_MIN);

    // Mix weight above one is clamped, and music is muted by the enable bit even
    // though it is flagged valid. The pulse phase left over from above plus the largest
    // pulse step closes the gate on the second beat.
    configure(itm_pkg::INC_W'(32'h1234_5678), '1, itm_pkg::AMP_W'(16384), '1, 1'b0, 1'b0);
    send_beat(KIND_PRODUCE, SAMPLE_MIN, 1'b1, 16'sd12345);
    send_beat(KIND_PRODUCE, SAMPLE_MAX, 1'b1, '0);
    send_beat(KIND_PRODUCE, pick_sample(), 1'b1, pick_sample());
    send_beat(KIND_STOP, pick_sample(), 1'b0, pick_sample());
    send_beat(KIND_PRODUCE, pick_sample(), 1'b1, pick_sample());

    // Random phases, each under fresh settings and its own idle odds. The last phase
    // runs with both sides at full rate.
    for (int unsigned phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      random_config();
      if (phase_no == RANDOM_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end
      repeat (BEATS_PER_PHASE) random_beat();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
